/* hdl/signal_priority_queue_unit_macros.svh */
// Assertion macros for the signal priority queue unit.
// Included by the RTL files that carry concurrent checks; uses clk and arst_n of the includer.
`ifndef SIGNAL_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SIGNAL_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH
// Condition that holds at every clock edge outside reset
`define SPQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Antecedent this cycle implies consequent in the next cycle
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SPQ_ASSERT(lbl, cond, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/spq_pkg.sv */
// Package for the signal priority queue unit: sizes, codes, item and state types.
// No dependencies; imported by signal_priority_queue_unit, spq_scoreboard_pkg and tb.
package spq_pkg;

	// Store sizing
	localparam int QUEUE_DEPTH  = 32;
	localparam int PAYLOAD_BITS = 32;
	localparam int SIG_BITS     = 7;
	localparam int IDX_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// Command codes
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_ENQUEUED = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_DEQUEUED = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_SHIFT
	} state_t;

	// Input item
	typedef struct packed {
		logic                    cmd;
		logic [SIG_BITS-1:0]     signal_number;
		logic [PAYLOAD_BITS-1:0] signal_payload;
	} spq_in_t;

	// Result item
	typedef struct packed {
		status_t                 status;
		logic [SIG_BITS-1:0]     out_signal;
		logic [PAYLOAD_BITS-1:0] out_payload;
	} spq_out_t;

	// One stored entry
	typedef struct packed {
		logic [SIG_BITS-1:0]     sig;
		logic [PAYLOAD_BITS-1:0] pay;
	} entry_t;

endpackage

/* hdl/signal_priority_queue_unit.sv */
// Signal priority queue unit: arrival-ordered entry store served lowest signal first.
// Depends on spq_pkg and signal_priority_queue_unit_macros.svh.
//
// channel   direction  handshake             payload
// request   in         start high, busy low  spq_in_t  (cmd, signal_number, signal_payload)
// result    out        done, one cycle       spq_out_t (status, out_signal, out_payload)
//
// Enqueue (stored, full or not) and an empty dequeue are completed from idle and never raise busy.
// A dequeue holds busy while it makes one memory read per entry for the minimum scan, then one
// read and one write per entry above the winner to close the gap; none of the latter are needed
// when the winner is the newest entry. The single read port of the entry memory and its
// registered read data set this pace.
// Each result appears on the cycle after its item finishes and the receiver cannot stall it;
// reset empties the store at once.
`include "signal_priority_queue_unit_macros.svh"

module signal_priority_queue_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spq_pkg::spq_in_t  request,
	output logic              done,
	output spq_pkg::spq_out_t result
);
	import spq_pkg::*;

	// Entry memory, one write and one read port, registered read data
	entry_t entry_mem [QUEUE_DEPTH];

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] scan_addr_q, scan_addr_d;
	logic [CNT_W-1:0] shift_rd_q, shift_rd_d;
	logic [IDX_W-1:0] best_idx_q, best_idx_d;
	entry_t           best_q, best_d;
	logic             done_q, done_d;
	spq_out_t         result_q, result_d;

	logic             rd_en, rd_shift;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_valid_s1, rd_shift_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	entry_t           rd_data_s1;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             accept;
	logic             better;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Memory write and read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= entry_mem[rd_addr];
		end
		rd_idx_s1 <= rd_addr;
	end

	// Control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			done_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_shift_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			done_q      <= done_d;
			rd_valid_s1 <= rd_en;
			rd_shift_s1 <= rd_shift;
		end
	end

	// Payload registers, no reset needed
	always_ff @(posedge clk) begin
		scan_addr_q <= scan_addr_d;
		shift_rd_q  <= shift_rd_d;
		best_idx_q  <= best_idx_d;
		best_q      <= best_d;
		result_q    <= result_d;
	end

	// Next state, memory control and result
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		scan_addr_d = scan_addr_q;
		shift_rd_d  = shift_rd_q;
		best_idx_d  = best_idx_q;
		best_d      = best_q;
		done_d      = 1'b0;
		result_d    = '0;
		rd_en       = 1'b0;
		rd_shift    = 1'b0;
		rd_addr     = scan_addr_q;
		wr_en       = 1'b0;
		wr_addr     = count_q[IDX_W-1:0];
		wr_data     = '{sig: request.signal_number, pay: request.signal_payload};

		// Running minimum; strict less-than keeps the oldest among equals
		better = rd_valid_s1 && !rd_shift_s1 &&
			((rd_idx_s1 == '0) || (rd_data_s1.sig < best_q.sig));
		if (better) begin
			best_d     = rd_data_s1;
			best_idx_d = rd_idx_s1;
		end

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (request.cmd == CMD_ENQUEUE) begin
						done_d = 1'b1;
						if (count_q == CNT_FULL) begin
							result_d.status = STAT_FULL;
						end else begin
							wr_en           = 1'b1;
							count_d         = count_q + 1'b1;
							result_d.status = STAT_ENQUEUED;
						end
					end else if (count_q == '0) begin
						done_d          = 1'b1;
						result_d.status = STAT_EMPTY;
					end else begin
						scan_addr_d = '0;
						state_d     = ST_SCAN;
					end
				end
			end
			// One read per stored entry, oldest first
			ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = scan_addr_q;
				if (CNT_W'(scan_addr_q) == count_q - 1'b1) begin
					state_d = ST_SCAN_END;
				end else begin
					scan_addr_d = scan_addr_q + 1'b1;
				end
			end
			// Last scan data lands; gap closing starts just above the winner
			ST_SCAN_END: begin
				shift_rd_d = CNT_W'(best_idx_d) + 1'b1;
				state_d    = ST_SHIFT;
			end
			// Read entry i, write it back at i-1 in the next cycle
			ST_SHIFT: begin
				if (shift_rd_q != count_q) begin
					rd_en      = 1'b1;
					rd_shift   = 1'b1;
					rd_addr    = shift_rd_q[IDX_W-1:0];
					shift_rd_d = shift_rd_q + 1'b1;
				end
				if (rd_valid_s1 && rd_shift_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1 - 1'b1;
					wr_data = rd_data_s1;
				end else if (shift_rd_q == count_q) begin
					count_d              = count_q - 1'b1;
					done_d               = 1'b1;
					result_d.status      = STAT_DEQUEUED;
					result_d.out_signal  = best_q.sig;
					result_d.out_payload = best_q.pay;
					state_d              = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Checks
	`SPQ_ASSERT(a_count_bound, count_q <= CNT_FULL, "entry count beyond depth")
	`SPQ_ASSERT(a_done_idle, !done_q || state_q == ST_IDLE, "result while still busy")
	`SPQ_ASSERT(a_shift_read_state, !(rd_valid_s1 && rd_shift_s1) || state_q == ST_SHIFT,
		"gap-closing read data outside shift phase")
	`SPQ_ASSERT(a_busy_nonempty, state_q == ST_IDLE || count_q != '0, "dequeue on empty store")
	`SPQ_ASSERT_NEXT(a_enq_count,
		accept && request.cmd == CMD_ENQUEUE && count_q != CNT_FULL,
		count_q == $past(count_q) + 1'b1 && done_q, "enqueue did not grow the store")

endmodule

/* bench/spq_scoreboard_pkg.sv */
// Scoreboard for the signal priority queue unit: mirrors the entry store and checks each result.
// Depends on spq_pkg for the item, entry and status types.
package spq_scoreboard_pkg;
	import spq_pkg::*;

	class spq_scoreboard;
		// Mirror of the store, oldest entry at the front
		entry_t      pending_entries[$];
		// Results still owed by the unit, oldest first
		spq_out_t    owed_results[$];
		int unsigned fail_count;

		function new();
			fail_count = 0;
		endfunction

		// Apply an accepted item to the mirror and queue the result it must give
		function void note_request(spq_in_t req);
			spq_out_t res;
			entry_t   ent;
			int       best;
			res = '0;
			if (req.cmd == CMD_ENQUEUE) begin
				if (pending_entries.size() >= QUEUE_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					ent.sig = req.signal_number;
					ent.pay = req.signal_payload;
					pending_entries.push_back(ent);
					res.status = STAT_ENQUEUED;
				end
			end else if (pending_entries.size() == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				// strict less-than keeps the oldest among equal numbers
				best = 0;
				for (int i = 1; i < pending_entries.size(); i++) begin
					if (pending_entries[i].sig < pending_entries[best].sig)
						best = i;
				end
				res.status      = STAT_DEQUEUED;
				res.out_signal  = pending_entries[best].sig;
				res.out_payload = pending_entries[best].pay;
				pending_entries.delete(best);
			end
			owed_results.push_back(res);
		endfunction

		// Compare a result from the unit with the oldest one owed
		function void check_result(spq_out_t got);
			spq_out_t want;
			if (owed_results.size() == 0) begin
				$error("result with no item outstanding: status %0d signal %0d payload %h",
					got.status, got.out_signal, got.out_payload);
				fail_count++;
				return;
			end
			want = owed_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fail_count++;
			end
			if (got.out_signal !== want.out_signal) begin
				$error("out_signal: expected %0d, got %0d", want.out_signal, got.out_signal);
				fail_count++;
			end
			if (got.out_payload !== want.out_payload) begin
				$error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
				fail_count++;
			end
		endfunction
	endclass

endpackage

/* bench/tb.sv */
// Testbench for signal_priority_queue_unit: directed and random enqueue/dequeue items.
// Depends on spq_pkg and spq_scoreboard_pkg; results are checked as they appear.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;
	import spq_scoreboard_pkg::*;

	localparam int RANDOM_ITEMS = 830;
	localparam int QUIET_ITEMS  = 100;
	localparam int STALL_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 100;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	spq_in_t  request;
	logic     done;
	spq_out_t result;

	spq_scoreboard book = new();
	int unsigned   stall_cycles;

	signal_priority_queue_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			book.check_result(result);
	end

	// Watchdog: cycles with neither an item taken nor a result given
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Present one item and hold it until the unit takes it
	task automatic send_item(input spq_in_t item);
		@(negedge clk);
		start   <= 1'b1;
		request <= item;
		do
			@(posedge clk);
		while (busy);
		book.note_request(item);
	endtask

	// Sender gap of the given number of cycles
	task automatic idle(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop sending until every owed result has come back
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (book.owed_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic spq_in_t make_enqueue(logic [SIG_BITS-1:0] sig,
		logic [PAYLOAD_BITS-1:0] pay);
		spq_in_t item;
		item.cmd            = CMD_ENQUEUE;
		item.signal_number  = sig;
		item.signal_payload = pay;
		return item;
	endfunction

	// Signal and payload fields are don't-care on a dequeue, so randomise them
	function automatic spq_in_t make_dequeue();
		spq_in_t item;
		item.cmd            = CMD_DEQUEUE;
		item.signal_number  = SIG_BITS'($urandom_range(0, 127));
		item.signal_payload = $urandom;
		return item;
	endfunction

	// Mostly legal signals, some narrow ranges for ties, some above 64
	function automatic logic [SIG_BITS-1:0] pick_signal();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return SIG_BITS'($urandom_range(0, 64));
		else if (r < 8)
			return SIG_BITS'($urandom_range(0, 3));
		else
			return SIG_BITS'($urandom_range(65, 127));
	endfunction

	// Stimulus
	initial begin
		int sent;
		int phase;
		int mode;
		int len;
		int enq_pct;
		bit paused_mid;

		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty dequeue, field extremes, ties, then drain past empty
		send_item(make_dequeue());
		send_item(make_enqueue(7'd5, 32'h0000_0000));
		send_item(make_enqueue(7'd5, 32'hFFFF_FFFF));
		send_item(make_enqueue(7'd0, 32'hA5A5_A5A5));
		send_item(make_enqueue(7'd127, 32'h5A5A_5A5A));
		send_item(make_enqueue(7'd64, 32'h1234_5678));
		send_item(make_enqueue(7'd5, 32'h0F0F_0F0F));
		send_item(make_enqueue(7'd0, 32'hF0F0_F0F0));
		repeat (7) send_item(make_dequeue());
		send_item(make_dequeue());
		wait_drained();

		// Random phases; the first floods the store past full
		sent = 0;
		phase = 0;
		paused_mid = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			mode = (phase == 0) ? 3 : $urandom_range(0, 4);
			len  = (phase == 0) ? 40 : $urandom_range(20, 70);
			case (mode)
				0: enq_pct = 50;
				1: enq_pct = 80;
				2: enq_pct = 20;
				3: enq_pct = 100;
				default: enq_pct = 0;
			endcase
			for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
				if (sent < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0)
					idle($urandom_range(1, 12));
				if ($urandom_range(1, 100) <= enq_pct)
					send_item(make_enqueue(pick_signal(), $urandom));
				else
					send_item(make_dequeue());
				sent++;
			end
			if (!paused_mid && sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused_mid = 1'b1;
			end
			phase++;
		end

		// Drain and let the unit settle
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
